@@ hw/rtl/fsrm_pkg.sv @@
// ----------------------------------------------------------------------------
// fsrm_pkg
// Shared types and codes of the frame slot ring manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fsrm_pkg;

   localparam int unsigned DEFAULT_RING_SIZE = 4;
   localparam int unsigned MASK_W            = 4;
   localparam int unsigned SLOT_FIELD_W      = 2;
   localparam int unsigned GEN_W             = 16;
   localparam int unsigned DIM_W             = 14;

   typedef enum logic [1:0] {
      OP_FRAME   = 2'd0,
      OP_POP     = 2'd1,
      OP_RECYCLE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_DROPPED   = 3'd1,
      ST_IGNORED   = 3'd2,
      ST_POPPED    = 3'd3,
      ST_POP_EMPTY = 3'd4,
      ST_RECYCLED  = 3'd5,
      ST_STALE     = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]              op;
      logic [DIM_W-1:0]        width;
      logic [DIM_W-1:0]        height;
      logic [MASK_W-1:0]       gpu_free_mask;
      logic [SLOT_FIELD_W-1:0] slot_index;
      logic [GEN_W-1:0]        generation_tag;
      logic                    consumed;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] out_slot;
      logic [GEN_W-1:0]        out_generation;
      logic [DIM_W-1:0]        out_width;
      logic [DIM_W-1:0]        out_height;
      logic                    ring_rebuilt;
      logic                    evicted;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/frame_slot_ring_manager.sv @@
// ----------------------------------------------------------------------------
// frame_slot_ring_manager
// Tracks ownership of a ring of frame slots shared by producer and consumer.
// ----------------------------------------------------------------------------
// channel   dir   tuser          tdata
// req_      in    op             width, height, gpu_free_mask, slot_index,
//                                generation_tag, consumed
// rsp_      out   status         out_slot, out_generation, out_width,
//                                out_height, ring_rebuilt, evicted
//
// one beat per cycle sustained while rsp_tready is high; each request gives one response
// after acceptance, through the input register and then the result register
// the event is resolved in one pass by the engine between the two registers
// reset is synchronous; it empties the ring, pending queue and both stages
// a stalled rsp_tready holds the result register and, once the input
// register is also full, drops req_tready in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module frame_slot_ring_manager
   import fsrm_pkg::*;
#(
   parameter int unsigned RING_SIZE = DEFAULT_RING_SIZE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,  // op
   // width, height, gpu_free_mask, slot_index, generation_tag, consumed, zero fill
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,  // status
   // out_slot, out_generation, out_width, out_height, ring_rebuilt, evicted
   output logic [47:0]      rsp_tdata
);

   req_type req_beat;
   req_type req_held;
   rsp_type rsp_calc;
   rsp_type rsp_held;
   logic    held_valid;
   logic    res_ready;

   assign req_beat.op             = req_tuser;
   assign req_beat.width          = req_tdata[13:0];
   assign req_beat.height         = req_tdata[27:14];
   assign req_beat.gpu_free_mask  = req_tdata[31:28];
   assign req_beat.slot_index     = req_tdata[33:32];
   assign req_beat.generation_tag = req_tdata[49:34];
   assign req_beat.consumed       = req_tdata[50];

   fsrm_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_beat),
      .take      (res_ready),
      .out_valid (held_valid),
      .out_data  (req_held)
   );

   fsrm_engine #(
      .RING_SIZE (RING_SIZE)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .commit (held_valid && res_ready),
      .req    (req_held),
      .rsp    (rsp_calc)
   );

   fsrm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_ready  (res_ready),
      .in_data   (rsp_calc),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_held)
   );

   assign rsp_tuser = rsp_held.status;
   assign rsp_tdata = {rsp_held.evicted, rsp_held.ring_rebuilt, rsp_held.out_height,
                       rsp_held.out_width, rsp_held.out_generation, rsp_held.out_slot};

   // eviction only happens when a frame is stored
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47] |-> rsp_tuser == ST_STORED)
      else $error("eviction reported without a stored frame");

   // a rebuild only comes with an arrival that was stored or dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[46] |-> rsp_tuser == ST_STORED || rsp_tuser == ST_DROPPED)
      else $error("rebuild reported on a non-arrival");

   // both registers full and stalled must close the input side
   assert property (@(posedge clock) disable iff (reset)
      held_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted with the pipeline full");

endmodule

`default_nettype wire

@@ hw/rtl/fsrm_in_stage.sv @@
// ----------------------------------------------------------------------------
// fsrm_in_stage
// Input register holding one request beat until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fsrm_in_stage
   import fsrm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   input  wire logic    take,
   output logic         out_valid,
   output req_type      out_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign in_ready  = !valid_ff || take;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/fsrm_engine.sv @@
// ----------------------------------------------------------------------------
// fsrm_engine
// Slot ownership state and the single-pass resolve of one event.
// ----------------------------------------------------------------------------
`default_nettype none

module fsrm_engine
   import fsrm_pkg::*;
#(
   parameter int unsigned RING_SIZE = DEFAULT_RING_SIZE
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    commit,
   input  wire req_type req,
   output rsp_type      rsp
);

   localparam int unsigned SLOT_W = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
   localparam int unsigned CNT_W  = $clog2(RING_SIZE + 1);

   logic [RING_SIZE-1:0] busy_ff, busy_in;
   logic [SLOT_W-1:0]    next_ff, next_in;
   logic [GEN_W-1:0]     gen_ff, gen_in;
   logic [DIM_W-1:0]     cw_ff, cw_in;
   logic [DIM_W-1:0]     ch_ff, ch_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]    pend_ff [RING_SIZE];
   logic [SLOT_W-1:0]    pend_in [RING_SIZE];

   logic [RING_SIZE+MASK_W-1:0] mask_ext;
   logic [RING_SIZE-1:0]        avail;
   logic [RING_SIZE-1:0]        from_next;
   logic [RING_SIZE-1:0]        avail_hi;
   logic [SLOT_W-1:0]           pick_hi;
   logic [SLOT_W-1:0]           pick_lo;
   logic [SLOT_W-1:0]           pick;

   assign mask_ext  = {{RING_SIZE{1'b0}}, req.gpu_free_mask};
   assign from_next = {RING_SIZE{1'b1}} << next_ff;

   always_comb begin
      busy_in  = busy_ff;
      next_in  = next_ff;
      gen_in   = gen_ff;
      cw_in    = cw_ff;
      ch_in    = ch_ff;
      count_in = count_ff;
      pend_in  = pend_ff;
      avail    = '0;
      avail_hi = '0;
      pick_hi  = '0;
      pick_lo  = '0;
      pick     = '0;
      rsp      = '0;
      rsp.status = ST_IGNORED;

      case (req.op)
         OP_FRAME: begin
            if (req.width != '0 && req.height != '0) begin
               // a new content size starts a fresh generation of the ring
               if (req.width != cw_ff || req.height != ch_ff) begin
                  busy_in  = '0;
                  count_in = '0;
                  cw_in    = req.width;
                  ch_in    = req.height;
                  gen_in   = gen_ff + 1'b1;
                  rsp.ring_rebuilt = 1'b1;
               end
               for (int s = 0; s < RING_SIZE; s++) begin
                  avail[s] = !busy_in[s] && mask_ext[s];
               end
               avail_hi = avail & from_next;
               // lowest set bit at or after the pointer, else lowest overall
               for (int s = RING_SIZE - 1; s >= 0; s--) begin
                  if (avail_hi[s]) pick_hi = SLOT_W'(s);
                  if (avail[s])    pick_lo = SLOT_W'(s);
               end
               pick = (|avail_hi) ? pick_hi : pick_lo;
               if (|avail) begin
                  busy_in[pick] = 1'b1;
                  next_in = (int'(pick) == RING_SIZE - 1) ? '0 : pick + 1'b1;
                  if (int'(count_in) >= RING_SIZE) begin
                     // oldest pending beat gives way; its slot may be the pick itself
                     busy_in[pend_in[0]] = 1'b0;
                     for (int i = 0; i < RING_SIZE - 1; i++) begin
                        pend_in[i] = pend_ff[i+1];
                     end
                     count_in    = CNT_W'(RING_SIZE - 1);
                     rsp.evicted = 1'b1;
                  end
                  pend_in[count_in[SLOT_W-1:0]] = pick;
                  count_in     = count_in + 1'b1;
                  rsp.status   = ST_STORED;
                  rsp.out_slot = SLOT_FIELD_W'(pick);
               end else begin
                  rsp.status = ST_DROPPED;
               end
            end
         end
         OP_POP: begin
            if (count_ff == '0 || int'(count_ff) > RING_SIZE) begin
               rsp.status = ST_POP_EMPTY;
            end else begin
               rsp.out_slot = SLOT_FIELD_W'(pend_ff[SLOT_W'(count_ff - 1'b1)]);
               for (int i = 0; i < RING_SIZE; i++) begin
                  if (i + 1 < int'(count_ff)) busy_in[pend_ff[i]] = 1'b0;
               end
               rsp.status = ST_POPPED;
            end
            count_in = '0;
         end
         OP_RECYCLE: begin
            if (int'(req.slot_index) >= RING_SIZE || req.generation_tag != gen_ff) begin
               rsp.status = ST_STALE;
            end else begin
               busy_in[SLOT_W'(req.slot_index)] = 1'b0;
               rsp.status   = ST_RECYCLED;
               rsp.out_slot = req.slot_index;
            end
         end
         default: begin
            rsp.status = ST_IGNORED;
         end
      endcase

      rsp.out_generation = gen_in;
      rsp.out_width      = cw_in;
      rsp.out_height     = ch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '0;
         next_ff  <= '0;
         gen_ff   <= '0;
         cw_ff    <= '0;
         ch_ff    <= '0;
         count_ff <= '0;
      end else if (commit) begin
         busy_ff  <= busy_in;
         next_ff  <= next_in;
         gen_ff   <= gen_in;
         cw_ff    <= cw_in;
         ch_ff    <= ch_in;
         count_ff <= count_in;
      end
      if (commit) begin
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/fsrm_out_stage.sv @@
// ----------------------------------------------------------------------------
// fsrm_out_stage
// Result register; holds a finished beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fsrm_out_stage
   import fsrm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire
